### rtl/cfr_pkg.sv
// Shared constants, codes and controller command type for the clock frame table.
`default_nettype none

package cfr_pkg;

  localparam int FRAME_SLOTS      = 64;
  localparam int PAGE_NUMBER_BITS = 20;
  localparam int SLOT_BITS        = $clog2(FRAME_SLOTS);
  localparam int OFFS_BITS        = SLOT_BITS + 1;

  localparam int OPCODE_BITS   = 3;
  localparam int PAGE_IN_BITS  = 20;
  localparam int STATUS_BITS   = 2;
  localparam int SLOT_OUT_BITS = 6;
  localparam int VICTIM_BITS   = 20;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_PIN    = 3'd2,
    OP_UNPIN  = 3'd3,
    OP_MARK   = 3'd4,
    OP_EVICT  = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_VICTIM = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_LOOK  = 2'd1,
    S_PICK  = 2'd2,
    S_APPLY = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic look;
    logic pick;
    logic apply;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/cfr_ctrl.sv
// Controller state machine that sequences one beat through lookup, pick and update.
`default_nettype none

module cfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output cfr_pkg::cmd_t cmd
);
  import cfr_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   apply_go;

  assign apply_go = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_PICK;
      S_PICK:  state_nxt = S_APPLY;
      S_APPLY: if (apply_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load  = (state_r == S_IDLE) && in_valid;
    cmd.look  = (state_r == S_LOOK);
    cmd.pick  = (state_r == S_PICK);
    cmd.apply = apply_go;
    in_stall  = (state_r != S_IDLE);
    out_valid = out_valid_r;
    if (apply_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/cfr_dp.sv
// Datapath with slot flags, page tags, clock hand, search logic and result register.
`default_nettype none

module cfr_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  cfr_pkg::cmd_t                        cmd,
  input  logic [cfr_pkg::OPCODE_BITS-1:0]      in_opcode,
  input  logic [cfr_pkg::PAGE_IN_BITS-1:0]     in_page_number,
  output logic [cfr_pkg::STATUS_BITS-1:0]      out_status,
  output logic [cfr_pkg::SLOT_OUT_BITS-1:0]    out_slot_index,
  output logic [cfr_pkg::VICTIM_BITS-1:0]      out_victim_page
);
  import cfr_pkg::*;

  typedef struct packed {
    logic                 any;
    logic [SLOT_BITS-1:0] idx;
  } pick_t;

  function automatic pick_t first_set(input logic [FRAME_SLOTS-1:0] v);
    pick_t p;
    p = '0;
    for (int i = FRAME_SLOTS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p.any = 1'b1;
        p.idx = SLOT_BITS'(i);
      end
    end
    return p;
  endfunction

  function automatic logic [OFFS_BITS-1:0] offset_of(input logic [SLOT_BITS-1:0] s,
                                                     input logic [SLOT_BITS-1:0] st);
    logic [OFFS_BITS-1:0] r;
    if (s >= st) begin
      r = OFFS_BITS'(s) - OFFS_BITS'(st);
    end else begin
      r = OFFS_BITS'(s) + OFFS_BITS'(FRAME_SLOTS) - OFFS_BITS'(st);
    end
    return r;
  endfunction

  logic [FRAME_SLOTS-1:0]      valid_r, valid_nxt;
  logic [FRAME_SLOTS-1:0]      pinned_r, pinned_nxt;
  logic [FRAME_SLOTS-1:0]      acc_r, acc_nxt;
  logic [PAGE_NUMBER_BITS-1:0] page_mem [FRAME_SLOTS];
  logic [SLOT_BITS-1:0]        hand_r, hand_nxt;
  logic                        hand_set_r, hand_set_nxt;

  opcode_t                     op_r;
  logic [PAGE_NUMBER_BITS-1:0] pg_r;
  logic [FRAME_SLOTS-1:0]      match_r, match_nxt;

  status_t                     status_r, status_nxt;
  logic [SLOT_BITS-1:0]        idx_r, idx_nxt;
  logic                        act_r, act_nxt;
  logic [FRAME_SLOTS-1:0]      clr_r, clr_nxt;

  logic [STATUS_BITS-1:0]      res_status_r;
  logic [SLOT_OUT_BITS-1:0]    res_slot_r;
  logic [VICTIM_BITS-1:0]      res_victim_r;

  logic [SLOT_BITS-1:0]        start;
  logic [FRAME_SLOTS-1:0]      evictable, cand, ge_mask, before_mask, after_mask;
  pick_t                       free_p, hit_p, cand_lo, cand_hi, ev_lo, ev_hi;
  pick_t                       vic_a, vic_b, nv_p;
  logic [OFFS_BITS-1:0]        found_offs;

  // Tag match over every slot.
  always_comb begin
    for (int s = 0; s < FRAME_SLOTS; s++) begin
      match_nxt[s] = valid_r[s] && (page_mem[s] == pg_r);
    end
  end

  // Clock search: first candidate at or after the hand, else the first from slot zero.
  assign start     = hand_set_r ? hand_r : '0;
  assign evictable = valid_r & ~pinned_r;
  assign cand      = evictable & ~acc_r;

  always_comb begin
    for (int s = 0; s < FRAME_SLOTS; s++) begin
      ge_mask[s] = (SLOT_BITS'(s) >= start);
    end
  end

  assign free_p  = first_set(~valid_r);
  assign hit_p   = first_set(match_r);
  assign cand_hi = first_set(cand & ge_mask);
  assign cand_lo = first_set(cand);
  assign ev_hi   = first_set(evictable & ge_mask);
  assign ev_lo   = first_set(evictable);
  assign vic_a   = cand_hi.any ? cand_hi : cand_lo;
  assign vic_b   = ev_hi.any ? ev_hi : ev_lo;

  assign found_offs = offset_of(vic_a.idx, start);

  always_comb begin
    for (int s = 0; s < FRAME_SLOTS; s++) begin
      before_mask[s] = (offset_of(SLOT_BITS'(s), start) < found_offs);
    end
  end

  always_comb begin
    status_nxt = ST_OK;
    idx_nxt    = '0;
    act_nxt    = 1'b0;
    clr_nxt    = '0;
    case (op_r)
      OP_INSERT: begin
        if (free_p.any) begin
          act_nxt = 1'b1;
          idx_nxt = free_p.idx;
        end else begin
          status_nxt = ST_FULL;
        end
      end
      OP_DELETE, OP_PIN, OP_UNPIN, OP_MARK: begin
        if (hit_p.any) begin
          act_nxt = 1'b1;
          idx_nxt = hit_p.idx;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_EVICT: begin
        if (vic_a.any) begin
          act_nxt = 1'b1;
          idx_nxt = vic_a.idx;
          clr_nxt = evictable & acc_r & before_mask;
        end else if (vic_b.any) begin
          act_nxt = 1'b1;
          idx_nxt = vic_b.idx;
          clr_nxt = evictable;
        end else begin
          status_nxt = ST_NO_VICTIM;
        end
      end
      default: ;
    endcase
  end

  // Next occupied slot above the target, for moving the hand.
  always_comb begin
    for (int s = 0; s < FRAME_SLOTS; s++) begin
      after_mask[s] = (SLOT_BITS'(s) > idx_r);
    end
  end

  assign nv_p = first_set(valid_r & after_mask);

  always_comb begin
    valid_nxt    = valid_r;
    pinned_nxt   = pinned_r;
    acc_nxt      = acc_r;
    hand_nxt     = hand_r;
    hand_set_nxt = hand_set_r;
    if (cmd.apply && act_r) begin
      case (op_r)
        OP_INSERT: begin
          valid_nxt[idx_r]  = 1'b1;
          pinned_nxt[idx_r] = 1'b0;
          acc_nxt[idx_r]    = 1'b0;
        end
        OP_DELETE: begin
          valid_nxt[idx_r]  = 1'b0;
          pinned_nxt[idx_r] = 1'b0;
          acc_nxt[idx_r]    = 1'b0;
          if (hand_set_r && (hand_r == idx_r)) begin
            hand_nxt     = nv_p.any ? nv_p.idx : '0;
            hand_set_nxt = nv_p.any;
          end
        end
        OP_PIN:   pinned_nxt[idx_r] = 1'b1;
        OP_UNPIN: pinned_nxt[idx_r] = 1'b0;
        OP_MARK:  acc_nxt[idx_r]    = 1'b1;
        OP_EVICT: begin
          acc_nxt           = acc_r & ~clr_r;
          valid_nxt[idx_r]  = 1'b0;
          pinned_nxt[idx_r] = 1'b0;
          acc_nxt[idx_r]    = 1'b0;
          hand_nxt          = nv_p.any ? nv_p.idx : '0;
          hand_set_nxt      = nv_p.any;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      pinned_r   <= '0;
      acc_r      <= '0;
      hand_r     <= '0;
      hand_set_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      pinned_r   <= pinned_nxt;
      acc_r      <= acc_nxt;
      hand_r     <= hand_nxt;
      hand_set_r <= hand_set_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && act_r && (op_r == OP_INSERT)) begin
      page_mem[idx_r] <= pg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= opcode_t'(in_opcode);
      pg_r <= in_page_number[PAGE_NUMBER_BITS-1:0];
    end
    if (cmd.look) begin
      match_r <= match_nxt;
    end
    if (cmd.pick) begin
      status_r <= status_nxt;
      idx_r    <= idx_nxt;
      act_r    <= act_nxt;
      clr_r    <= clr_nxt;
    end
    if (cmd.apply) begin
      res_status_r <= status_r;
      res_slot_r   <= SLOT_OUT_BITS'(idx_r);
      res_victim_r <= (act_r && (op_r == OP_EVICT)) ?
                      VICTIM_BITS'(page_mem[idx_r]) : '0;
    end
  end

  assign out_status      = res_status_r;
  assign out_slot_index  = res_slot_r;
  assign out_victim_page = res_victim_r;

endmodule

`default_nettype wire

### rtl/clock_frame_replacement.sv
// Top level of the frame table with clock (second-chance) replacement.
//
// The input channel takes one beat per operation: an opcode and a page number.
// Each beat yields exactly one result beat with a status, a slot index and,
// for an evict, the victim page. Transfers happen when valid is high and
// stall is low on that channel.
// An accepted beat passes through tag match over all slots, then the
// free-slot, match and clock-hand priority encoders, then the table
// update, which also loads the output register. The input stalls until
// that update is done, so a new beat is not taken while one is in flight.
// The output register holds the result while the receiver stalls; the next
// beat is accepted meanwhile, but its update waits until the register frees.
// Synchronous reset empties the table, clears all flags, parks the hand at
// slot zero and drops the output valid.
`default_nettype none

module clock_frame_replacement (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cfr_pkg::OPCODE_BITS-1:0]      in_opcode,
  input  logic [cfr_pkg::PAGE_IN_BITS-1:0]     in_page_number,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cfr_pkg::STATUS_BITS-1:0]      out_status,
  output logic [cfr_pkg::SLOT_OUT_BITS-1:0]    out_slot_index,
  output logic [cfr_pkg::VICTIM_BITS-1:0]      out_victim_page
);
  import cfr_pkg::*;

  cmd_t cmd;

  cfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cfr_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_opcode       (in_opcode),
    .in_page_number  (in_page_number),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_victim_page (out_victim_page)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while an operation was still in flight");

  a_apply_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_slot_index == '0) && (out_victim_page == '0))
    else $error("failed operation reports nonzero slot or victim");

  a_valid_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.apply))
    else $error("output valid rose without a table update");

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the clock frame replacement table: random and directed operations.
`timescale 1ns / 100ps

module testbench;
  import cfr_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_OPS   = 950;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 300;
  localparam int HOLD_AFTER   = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL_SIZE    = 12;
  localparam int OP_KINDS     = 6;

  localparam logic [OPCODE_BITS-1:0] OP_RSVD_A = 3'd6;
  localparam logic [OPCODE_BITS-1:0] OP_RSVD_B = 3'd7;

  localparam logic [PAGE_IN_BITS-1:0] PG_LOW  = 20'h00000;
  localparam logic [PAGE_IN_BITS-1:0] PG_HIGH = 20'hFFFFF;
  localparam logic [PAGE_IN_BITS-1:0] PG_MID  = 20'hA5A5A;
  localparam logic [PAGE_IN_BITS-1:0] PG_ALT  = 20'h5A5A5;
  localparam logic [PAGE_IN_BITS-1:0] PG_MISS = 20'h12345;

  typedef struct packed {
    logic [OPCODE_BITS-1:0]  opcode;
    logic [PAGE_IN_BITS-1:0] page;
  } frame_op_t;

  typedef struct packed {
    status_t                   status;
    logic [SLOT_OUT_BITS-1:0]  slot;
    logic [VICTIM_BITS-1:0]    victim;
  } frame_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [OPCODE_BITS-1:0]   in_opcode = '0;
  logic [PAGE_IN_BITS-1:0]  in_page_number = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [STATUS_BITS-1:0]   out_status;
  logic [SLOT_OUT_BITS-1:0] out_slot_index;
  logic [VICTIM_BITS-1:0]   out_victim_page;

  frame_op_t     pending_ops [$];
  frame_result_t results_due [$];

  int fails = 0;
  int in_beats = 0;
  int out_beats = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  bit long_hold_done = 1'b0;

  int unsigned op_cut [4][OP_KINDS] = '{
    '{55, 60, 68, 74, 86, 97},
    '{25, 37, 49, 59, 75, 97},
    '{10, 20, 25, 40, 55, 97},
    '{20, 25, 55, 62, 75, 97}
  };
  opcode_t op_order [OP_KINDS] = '{OP_INSERT, OP_DELETE, OP_PIN, OP_UNPIN, OP_MARK, OP_EVICT};

  logic                        slot_used [FRAME_SLOTS] = '{default: 1'b0};
  logic                        slot_pin  [FRAME_SLOTS] = '{default: 1'b0};
  logic                        slot_ref  [FRAME_SLOTS] = '{default: 1'b0};
  logic [PAGE_NUMBER_BITS-1:0] slot_tag  [FRAME_SLOTS];
  int                          hand_slot = 0;
  logic                        hand_live = 1'b0;

  clock_frame_replacement DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_page_number  (in_page_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_victim_page (out_victim_page)
  );

  always #10 clk = ~clk;

  function automatic int find_page(input logic [PAGE_NUMBER_BITS-1:0] page);
    int s;
    for (s = 0; s < FRAME_SLOTS; s++) begin
      if (slot_used[s] && slot_tag[s] == page) return s;
    end
    return FRAME_SLOTS;
  endfunction

  // Removing the slot under the hand moves the hand to the next occupied slot.
  task automatic free_slot(input int s);
    int n;
    slot_used[s] = 1'b0;
    slot_pin[s] = 1'b0;
    slot_ref[s] = 1'b0;
    if (hand_live && hand_slot == s) begin
      n = s + 1;
      while (n < FRAME_SLOTS && !slot_used[n]) n++;
      if (n < FRAME_SLOTS) begin
        hand_slot = n;
      end else begin
        hand_slot = 0;
        hand_live = 1'b0;
      end
    end
  endtask

  task automatic frame_table_step(input frame_op_t item, output frame_result_t res);
    int s;
    int i;
    int start;
    int found;
    bit any_free;
    res.status = ST_OK;
    res.slot = '0;
    res.victim = '0;
    case (item.opcode)
      OP_INSERT: begin
        s = 0;
        while (s < FRAME_SLOTS && slot_used[s]) s++;
        if (s < FRAME_SLOTS) begin
          slot_used[s] = 1'b1;
          slot_pin[s] = 1'b0;
          slot_ref[s] = 1'b0;
          slot_tag[s] = item.page;
          res.slot = SLOT_OUT_BITS'(s);
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DELETE, OP_PIN, OP_UNPIN, OP_MARK: begin
        s = find_page(item.page);
        if (s < FRAME_SLOTS) begin
          res.slot = SLOT_OUT_BITS'(s);
          case (item.opcode)
            OP_DELETE: free_slot(s);
            OP_PIN:    slot_pin[s] = 1'b1;
            OP_UNPIN:  slot_pin[s] = 1'b0;
            OP_MARK:   slot_ref[s] = 1'b1;
            default: ;
          endcase
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_EVICT: begin
        any_free = 1'b0;
        for (s = 0; s < FRAME_SLOTS; s++) begin
          if (slot_used[s] && !slot_pin[s]) any_free = 1'b1;
        end
        if (!any_free) begin
          res.status = ST_NO_VICTIM;
        end else begin
          start = hand_live ? hand_slot : 0;
          found = FRAME_SLOTS;
          for (i = 0; i <= 2 * FRAME_SLOTS && found == FRAME_SLOTS; i++) begin
            s = (start + i) % FRAME_SLOTS;
            if (slot_used[s] && !slot_pin[s]) begin
              if (!slot_ref[s]) found = s;
              else slot_ref[s] = 1'b0;
            end
          end
          res.slot = SLOT_OUT_BITS'(found);
          res.victim = slot_tag[found];
          hand_slot = found;
          hand_live = 1'b1;
          free_slot(found);
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_op(input logic [OPCODE_BITS-1:0] opcode,
                          input logic [PAGE_IN_BITS-1:0] page);
    frame_op_t op;
    op.opcode = opcode;
    op.page = page;
    pending_ops.push_back(op);
  endtask

  always @(posedge clk) begin : op_driver
    frame_op_t next_op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        in_valid <= 1'b1;
        in_opcode <= next_op.opcode;
        in_page_number <= next_op.page;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 7);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long hold-off lets the block fill up and stall its input; otherwise the stall follows random modes.
  always @(posedge clk) begin : result_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && in_beats >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(10, 60);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_monitor
    frame_op_t     item;
    frame_result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        out_beats <= out_beats + 1;
        if (results_due.size() == 0) begin
          $error("result beat with no expected result pending");
          fails++;
        end else begin
          want = results_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_slot_index !== want.slot) begin
            $error("slot_index: expected %0d, got %0d", want.slot, out_slot_index);
            fails++;
          end
          if (out_victim_page !== want.victim) begin
            $error("victim_page: expected %h, got %h", want.victim, out_victim_page);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        in_beats <= in_beats + 1;
        item.opcode = in_opcode;
        item.page = in_page_number;
        frame_table_step(item, want);
        results_due.push_back(want);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int mode;
    int len;
    int roll;
    int k;
    int real_ops;
    int total;
    frame_op_t op;
    logic [PAGE_IN_BITS-1:0] pool [POOL_SIZE];

    // Empty table, misses, duplicates, second chance, pinned skips and a full wrap.
    queue_op(OP_EVICT, PG_HIGH);
    queue_op(OP_UNPIN, PG_MISS);
    queue_op(OP_INSERT, PG_LOW);
    queue_op(OP_INSERT, PG_HIGH);
    queue_op(OP_INSERT, PG_LOW);
    queue_op(OP_INSERT, PG_MID);
    queue_op(OP_MARK, PG_LOW);
    queue_op(OP_MARK, PG_HIGH);
    queue_op(OP_PIN, PG_MID);
    queue_op(OP_EVICT, PG_LOW);
    queue_op(OP_EVICT, PG_HIGH);
    queue_op(OP_DELETE, PG_HIGH);
    queue_op(OP_EVICT, PG_LOW);
    queue_op(OP_UNPIN, PG_MID);
    queue_op(OP_MARK, PG_MID);
    queue_op(OP_EVICT, PG_LOW);
    queue_op(OP_EVICT, PG_LOW);
    queue_op(OP_RSVD_A, PG_HIGH);
    queue_op(OP_RSVD_B, PG_ALT);
    queue_op(OP_INSERT, PG_ALT);
    queue_op(OP_PIN, PG_ALT);
    queue_op(OP_UNPIN, PG_ALT);
    queue_op(OP_DELETE, PG_MISS);
    queue_op(OP_MARK, PG_MISS);
    queue_op(OP_PIN, PG_MISS);

    foreach (pool[i]) pool[i] = PAGE_IN_BITS'($urandom());
    pool[0] = PG_LOW;
    pool[1] = PG_HIGH;
    real_ops = 0;
    while (real_ops < RANDOM_OPS) begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 90);
      pool[$urandom_range(2, POOL_SIZE - 1)] = PAGE_IN_BITS'($urandom());
      repeat (len) begin
        roll = $urandom_range(0, 99);
        k = 0;
        while (k < OP_KINDS && roll >= op_cut[mode][k]) k++;
        if (k < OP_KINDS) begin
          op.opcode = op_order[k];
          real_ops++;
        end else begin
          op.opcode = ($urandom_range(0, 1) == 0) ? OP_RSVD_A : OP_RSVD_B;
        end
        if ($urandom_range(0, 9) == 0) op.page = PAGE_IN_BITS'($urandom());
        else op.page = pool[$urandom_range(0, POOL_SIZE - 1)];
        pending_ops.push_back(op);
      end
    end
    total = pending_ops.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (in_beats != total || out_beats != total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (results_due.size() != 0) begin
      $error("%0d expected results never arrived", results_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/cfr_pkg.sv
rtl/cfr_ctrl.sv
rtl/cfr_dp.sv
rtl/clock_frame_replacement.sv
test/testbench.sv
